/* hw/rtl/scope_trigger_and_display_fetch_core_defines.svh */
// ----------------------------------------------------------------------------
// Scope trigger and display fetch: assertion macros
// Shared concurrent assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef SCOPE_TRIGGER_AND_DISPLAY_FETCH_CORE_DEFINES_SVH
`define SCOPE_TRIGGER_AND_DISPLAY_FETCH_CORE_DEFINES_SVH

// Same-cycle implication
`define STDF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("stdf assertion failed");

// Next-cycle implication
`define STDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stdf assertion failed");

`endif

/* hw/rtl/stdf_pkg.sv */
// ----------------------------------------------------------------------------
// Scope trigger and display fetch package
// Shared constants, codes and the types passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stdf_pkg;

  // Default sizes
  localparam int DEPTH_DEF  = 4096;
  localparam int SCREEN_DEF = 320;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int GAIN_W   = 16;
  localparam int VALUE_W  = 15;
  localparam int LEVEL_W  = 14;  // signed threshold width

  // Miss counter
  localparam logic [2:0] MISS_SAT        = 3'd7;
  localparam logic [2:0] MISS_SHOW_LIMIT = 3'd5;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 15'h7fff;

  // Operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRIG = 2'd1;
  localparam logic [1:0] OP_PIX  = 2'd2;

  // Frame status codes
  localparam logic [1:0] STAT_TRIG = 2'd0;
  localparam logic [1:0] STAT_HIDE = 2'd1;
  localparam logic [1:0] STAT_SHOW = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_TOL    = 3'd0;
  localparam logic [2:0] CFG_WIN    = 3'd1;
  localparam logic [2:0] CFG_TSTART = 3'd2;
  localparam logic [2:0] CFG_STEP   = 3'd3;
  localparam logic [2:0] CFG_GAIN   = 3'd4;

  // Configuration register file
  typedef struct packed {
    logic [11:0] tol;
    logic [6:0]  win;
    logic [11:0] tstart;
    logic [8:0]  step;
    logic [15:0] gain;
  } cfg_t;

  // Trigger scan completion
  typedef struct packed {
    logic done;
    logic hit;
  } trig_res_t;

endpackage

`default_nettype wire

/* hw/rtl/stdf_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stdf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/stdf_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration register bank
// Holds trigger and display settings, written through a valid/ready port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stdf_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output stdf_pkg::cfg_t   cfg_o
);

  stdf_pkg::cfg_t cfg_q, cfg_d;

  // Always able to take a write
  assign cfg_ready_o = 1'b1;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        stdf_pkg::CFG_TOL:    cfg_d.tol    = cfg_data_i[11:0];
        stdf_pkg::CFG_WIN:    cfg_d.win    = cfg_data_i[6:0];
        stdf_pkg::CFG_TSTART: cfg_d.tstart = cfg_data_i[11:0];
        stdf_pkg::CFG_STEP:   cfg_d.step   = cfg_data_i[8:0];
        stdf_pkg::CFG_GAIN:   cfg_d.gain   = cfg_data_i;
        default:              cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tol    <= 12'd16;
      cfg_q.win    <= 7'd8;
      cfg_q.tstart <= 12'd0;
      cfg_q.step   <= 9'd1;
      cfg_q.gain   <= 16'd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/stdf_trig.sv */
// ----------------------------------------------------------------------------
// Trigger scan engine
// Streams the capture memory one sample per cycle, tracking the latest
// above-high sample and stopping at the first below-low sample in its window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stdf_trig #(
  parameter int DEPTH  = stdf_pkg::DEPTH_DEF,
  parameter int SCREEN = stdf_pkg::SCREEN_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              go_i,
  input  stdf_pkg::cfg_t                         cfg_i,
  input  wire logic [stdf_pkg::SAMPLE_W-1:0]     amp_max_i,
  input  wire logic [stdf_pkg::SAMPLE_W-1:0]     amp_min_i,
  output logic      [$clog2(DEPTH)-1:0]          rd_addr_o,
  input  wire logic [stdf_pkg::SAMPLE_W-1:0]     rd_data_i,
  output stdf_pkg::trig_res_t                    res_o,
  output logic      [$clog2(DEPTH)-1:0]          hit_idx_o
);

  localparam int AW  = $clog2(DEPTH);
  localparam int IW  = ((AW > 12) ? AW : 12) + 1;
  localparam int END = DEPTH - SCREEN;
  localparam int LW  = stdf_pkg::LEVEL_W;

  logic                 run_q, run_d;
  logic [IW-1:0]        addr_q, addr_d;
  logic [IW-1:0]        rd_idx_q, rd_idx_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IW-1:0]        last_q, last_d;
  logic                 last_vld_q, last_vld_d;
  logic signed [LW-1:0] high_q, high_d;
  logic signed [LW-1:0] low_q, low_d;

  logic [12:0]          sum;
  logic [11:0]          centre;
  logic signed [LW-1:0] samp_s;
  logic [IW-1:0]        span, span_nxt, nxt_idx;
  logic                 is_lo, is_hi, in_win, hit, miss, pend;

  // Thresholds from the frame extremes
  always_comb begin
    sum    = {1'b0, amp_max_i} + {1'b0, amp_min_i};
    centre = sum[12:1];
    high_d = $signed({2'b00, centre}) + $signed({2'b00, cfg_i.tol});
    low_d  = $signed({2'b00, centre}) - $signed({2'b00, cfg_i.tol});
  end

  // Compare the sample returned for rd_idx_q
  always_comb begin
    samp_s     = $signed({2'b00, rd_data_i});
    is_lo      = samp_s < low_q;
    is_hi      = samp_s > high_q;
    span       = rd_idx_q - last_q;
    in_win     = last_vld_q && (span < IW'(cfg_i.win));
    hit        = run_q && rd_vld_q && is_lo && in_win;

    last_d     = last_q;
    last_vld_d = last_vld_q;
    if (run_q && rd_vld_q && is_hi && (rd_idx_q < IW'(END))) begin
      last_d     = rd_idx_q;
      last_vld_d = 1'b1;
    end
    // A new search starts with no open window
    if (go_i) begin
      last_vld_d = 1'b0;
    end

    // Nothing later can hit once past the search end with no open window
    nxt_idx  = rd_idx_q + IW'(1);
    span_nxt = nxt_idx - last_d;
    pend     = last_vld_d && (span_nxt < IW'(cfg_i.win));
    miss     = run_q && rd_vld_q && !hit &&
               ((nxt_idx >= IW'(DEPTH)) || ((nxt_idx >= IW'(END)) && !pend));
  end

  // Sequencing of reads and run control
  always_comb begin
    run_d    = run_q;
    addr_d   = addr_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = rd_vld_q;
    if (go_i) begin
      run_d    = 1'b1;
      addr_d   = IW'(cfg_i.tstart);
      rd_vld_d = 1'b0;
    end else if (run_q) begin
      addr_d   = addr_q + IW'(1);
      rd_idx_d = addr_q;
      rd_vld_d = 1'b1;
      if (hit || miss) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      rd_vld_q   <= 1'b0;
      last_vld_q <= 1'b0;
    end else begin
      run_q      <= run_d;
      rd_vld_q   <= rd_vld_d;
      last_vld_q <= last_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    rd_idx_q <= rd_idx_d;
    last_q   <= last_d;
    if (go_i) begin
      high_q <= high_d;
      low_q  <= low_d;
    end
  end

  assign rd_addr_o = addr_q[AW-1:0];
  assign res_o.done = hit || miss;
  assign res_o.hit  = hit;
  assign hit_idx_o  = rd_idx_q[AW-1:0];

endmodule

`default_nettype wire

/* hw/rtl/scope_trigger_and_display_fetch_core.sv */
// A load gives no result. A pixel read registers its address into the capture memory on
// acceptance and its scaled value into the result register in ST_PIX, then returns to ST_IDLE.
// Trigger search: one capture-memory read per cycle until a hit or a miss ends the
// scan; a search starting past the end answers next cycle.
// The receiver cannot stall; results are single-cycle strobes on valid_o.
// Reset restores config defaults, clears display start and miss count; capture RAM keeps data.
// ----------------------------------------------------------------------------
// Scope trigger and display fetch core
// Capture memory, hysteresis edge trigger search and scaled pixel fetch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "scope_trigger_and_display_fetch_core_defines.svh"

module scope_trigger_and_display_fetch_core #(
  parameter int DEPTH  = stdf_pkg::DEPTH_DEF,
  parameter int SCREEN = stdf_pkg::SCREEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op_i,
  input  wire logic [11:0] sample_index_i,
  input  wire logic [11:0] sample_value_i,
  input  wire logic [11:0] amp_max_i,
  input  wire logic [11:0] amp_min_i,
  input  wire logic [8:0]  pixel_index_i,
  output logic             valid_o,
  output logic [1:0]       frame_status_o,
  output logic [14:0]      display_value_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int AW  = $clog2(DEPTH);
  localparam int IW  = ((AW > 12) ? AW : 12) + 1;
  localparam int NW  = ((AW > 18) ? AW : 18) + 1;
  localparam int END = DEPTH - SCREEN;
  localparam int SW  = stdf_pkg::SAMPLE_W;
  localparam int VW  = stdf_pkg::VALUE_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PIX  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  stdf_pkg::cfg_t          cfg;
  stdf_pkg::trig_res_t     trig_res;
  logic [AW-1:0]           trig_raddr, hit_idx, ram_raddr;
  logic [SW-1:0]           ram_rdata;
  logic                    acc, acc_load, acc_trig, acc_pix, early_miss, trig_go;
  logic                    ram_we;
  logic [AW-1:0]           disp_start_q;
  logic [2:0]              miss_q, miss_next;
  logic [17:0]             pix_off;
  logic [NW-1:0]           pix_addr;
  logic                    pix_ok, pix_ok_q;
  logic [27:0]             prod;
  logic [19:0]             scaled;
  logic [VW-1:0]           pix_val;
  logic                    fin;
  logic                    valid_q, valid_d;
  logic [1:0]              status_q, status_d;
  logic [VW-1:0]           value_q, value_d;

  // Configuration registers
  stdf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Item acceptance and decode
  assign busy       = (state_q != ST_IDLE);
  assign acc        = start && !busy;
  assign acc_load   = acc && (op_i == stdf_pkg::OP_LOAD);
  assign acc_trig   = acc && (op_i == stdf_pkg::OP_TRIG);
  assign acc_pix    = acc && (op_i == stdf_pkg::OP_PIX);
  assign early_miss = IW'(cfg.tstart) >= IW'(END);
  assign trig_go    = acc_trig && !early_miss;
  assign ram_we     = acc_load && (IW'(sample_index_i) < IW'(DEPTH));

  // Pixel address, computed in the accept cycle
  always_comb begin
    pix_off  = 18'(pixel_index_i) * 18'(cfg.step);
    pix_addr = NW'(disp_start_q) + NW'(pix_off);
    pix_ok   = (11'(pixel_index_i) < 11'(SCREEN)) && (pix_addr < NW'(DEPTH));
  end

  assign ram_raddr = (state_q == ST_SCAN) ? trig_raddr : pix_addr[AW-1:0];

  // Capture memory
  stdf_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(sample_index_i)),
    .wdata_i (sample_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Trigger scan
  stdf_trig #(
    .DEPTH  (DEPTH),
    .SCREEN (SCREEN)
  ) u_trig (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (trig_go),
    .cfg_i     (cfg),
    .amp_max_i (amp_max_i),
    .amp_min_i (amp_min_i),
    .rd_addr_o (trig_raddr),
    .rd_data_i (ram_rdata),
    .res_o     (trig_res),
    .hit_idx_o (hit_idx)
  );

  // Control sequencing
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (trig_go) begin
          state_d = ST_SCAN;
        end else if (acc_pix) begin
          state_d = ST_PIX;
        end
      end
      ST_SCAN: begin
        if (trig_res.done) begin
          state_d = ST_IDLE;
        end
      end
      ST_PIX:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Pixel scaling with saturation
  always_comb begin
    prod    = 28'(ram_rdata) * 28'(cfg.gain);
    scaled  = prod[27:8];
    pix_val = (scaled > 20'(stdf_pkg::VALUE_MAX)) ? stdf_pkg::VALUE_MAX : scaled[VW-1:0];
    if (!pix_ok_q) begin
      pix_val = '0;
    end
  end

  // Trigger outcome and result registers
  always_comb begin
    fin       = (acc_trig && early_miss) || ((state_q == ST_SCAN) && trig_res.done);
    miss_next = (miss_q < stdf_pkg::MISS_SAT) ? (miss_q + 3'd1) : miss_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    value_d   = value_q;
    if (fin) begin
      valid_d  = 1'b1;
      value_d  = '0;
      if (trig_res.hit && (state_q == ST_SCAN)) begin
        status_d = stdf_pkg::STAT_TRIG;
      end else if (miss_next < stdf_pkg::MISS_SHOW_LIMIT) begin
        status_d = stdf_pkg::STAT_HIDE;
      end else begin
        status_d = stdf_pkg::STAT_SHOW;
      end
    end else if (state_q == ST_PIX) begin
      valid_d  = 1'b1;
      status_d = stdf_pkg::STAT_TRIG;
      value_d  = pix_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= 1'b0;
      disp_start_q <= '0;
      miss_q       <= 3'd0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (fin) begin
        if (trig_res.hit && (state_q == ST_SCAN)) begin
          disp_start_q <= hit_idx;
          miss_q       <= 3'd0;
        end else begin
          miss_q <= miss_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    value_q  <= value_d;
    if (acc_pix) begin
      pix_ok_q <= pix_ok;
    end
  end

  assign valid_o         = valid_q;
  assign frame_status_o  = status_q;
  assign display_value_o = value_q;

  // Checks
  `STDF_ASSERT_NEXT(a_pix_stage, clk_i, rst_ni, acc_pix, (state_q == ST_PIX))
  `STDF_ASSERT_NEXT(a_pix_result, clk_i, rst_ni, (state_q == ST_PIX), valid_o)
  `STDF_ASSERT_IMP(a_hide_count, clk_i, rst_ni, (valid_o && (frame_status_o == stdf_pkg::STAT_HIDE)), ((miss_q != 3'd0) && (miss_q < stdf_pkg::MISS_SHOW_LIMIT)))
  `STDF_ASSERT_IMP(a_value_status, clk_i, rst_ni, (valid_o && (display_value_o != 15'd0)), (frame_status_o == stdf_pkg::STAT_TRIG))

endmodule

`default_nettype wire
